/* hw/rtl/irl_pkg.sv */
// Package for the infrared receiver link handshake unit.
// Holds the phase type, the command type of the front-to-back queue and the codes.
// No dependencies.
`timescale 1ns / 1ps

package irl_pkg;

	localparam int TICK_W = 21;
	localparam int POS_W  = 4;
	localparam int KIND_W = 3;
	localparam int IDX_W  = 3;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	localparam logic [TICK_W-1:0] SETTLE_RST     = 21'd10000;
	localparam logic [TICK_W-1:0] QUIET_RST      = 21'd50000;
	localparam logic [TICK_W-1:0] SEND_GAP_RST   = 21'd500;
	localparam logic [TICK_W-1:0] REPLY_TO_RST   = 21'd2000000;
	localparam logic [TICK_W-1:0] INTER_BYTE_RST = 21'd1000;

	localparam logic [IDX_W-1:0] REG_SETTLE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_QUIET      = 3'd1;
	localparam logic [IDX_W-1:0] REG_SEND_GAP   = 3'd2;
	localparam logic [IDX_W-1:0] REG_REPLY_TO   = 3'd3;
	localparam logic [IDX_W-1:0] REG_INTER_BYTE = 3'd4;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_BYTE  = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;

	localparam logic [KIND_W-1:0] KIND_SEND          = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CODE          = 3'd1;
	localparam logic [KIND_W-1:0] KIND_READY         = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REPLY_TIMEOUT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BAD_REPLY     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CODE_TIMEOUT  = 3'd5;

	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_K = 8'h4B;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_FLUSH,
		PH_GAP,
		PH_WAIT_O,
		PH_WAIT_K,
		PH_READY
	} phase_t;

	typedef enum logic [1:0] {
		OP_SINGLE,
		OP_STORE,
		OP_CODE
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KIND_W-1:0] kind;
		logic [7:0]        data;
		logic [POS_W-1:0]  pos;
	} cmd_t;

endpackage

/* hw/rtl/irl_if.sv */
// Stream interfaces for the item and result channels of the link unit.
// Depends on irl_pkg for field widths.
`timescale 1ns / 1ps

interface irl_in_if import irl_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface irl_out_if import irl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [7:0]        data;
	logic [POS_W-1:0]  position;
	logic              last;

	modport source (output valid, output kind, output data, output position, output last,
		input ready);
	modport sink (input valid, input kind, input data, input position, input last,
		output ready);
endinterface

/* hw/rtl/irl_front.sv */
// Front part: accepts items, keeps the handshake phase and timers, and issues commands.
// Holds the configuration registers. Depends on irl_pkg and irl_if.
`timescale 1ns / 1ps

module irl_front import irl_pkg::*; #(
	parameter int CODE_BYTES = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [TICK_W-1:0] wr_data,
	irl_in_if.sink            item,
	input  logic              space,
	output logic              push,
	output cmd_t              cmd
);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_BYTES - 1);

	logic [TICK_W-1:0] settle_q, quiet_q, send_gap_q, reply_to_q, inter_byte_q;
	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] elapsed_q, elapsed_d, elapsed_inc, limit;
	logic [POS_W-1:0]  held_q, held_d;
	logic              acc, is_tick, is_byte, is_start, done;

	assign item.ready = space;
	assign acc        = item.valid && space;
	assign is_tick    = item.mode == MODE_TICK;
	assign is_byte    = item.mode == MODE_BYTE;
	assign is_start   = item.mode == MODE_START;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q     <= SETTLE_RST;
			quiet_q      <= QUIET_RST;
			send_gap_q   <= SEND_GAP_RST;
			reply_to_q   <= REPLY_TO_RST;
			inter_byte_q <= INTER_BYTE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SETTLE:     settle_q     <= wr_data;
				REG_QUIET:      quiet_q      <= wr_data;
				REG_SEND_GAP:   send_gap_q   <= wr_data;
				REG_REPLY_TO:   reply_to_q   <= wr_data;
				REG_INTER_BYTE: inter_byte_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (phase_q) inside
			PH_SETTLE:            limit = settle_q;
			PH_FLUSH:             limit = quiet_q;
			PH_GAP:               limit = send_gap_q;
			PH_WAIT_O, PH_WAIT_K: limit = reply_to_q;
			default:              limit = inter_byte_q;
		endcase
	end

	assign elapsed_inc = (elapsed_q != TICK_MAX) ? elapsed_q + 1'b1 : elapsed_q;
	assign done        = elapsed_inc >= limit;

	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			if (is_start) begin
				phase_d = PH_SETTLE;
			end else if (is_tick) begin
				unique case (phase_q) inside
					PH_SETTLE: if (done) phase_d = PH_FLUSH;
					PH_FLUSH:  if (done) phase_d = PH_GAP;
					PH_GAP:    if (done) phase_d = PH_WAIT_O;
					PH_WAIT_O, PH_WAIT_K: if (done) phase_d = PH_IDLE;
					default: ;
				endcase
			end else if (is_byte) begin
				unique case (phase_q) inside
					PH_WAIT_O: if (item.rx_byte == CH_O) phase_d = PH_WAIT_K;
					PH_WAIT_K: phase_d = (item.rx_byte == CH_K) ? PH_READY : PH_IDLE;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		elapsed_d = elapsed_q;
		held_d    = held_q;
		push      = 1'b0;
		cmd.op    = OP_SINGLE;
		cmd.kind  = KIND_SEND;
		cmd.data  = '0;
		cmd.pos   = '0;
		if (acc) begin
			if (is_start) begin
				elapsed_d = '0;
				held_d    = '0;
			end else if (is_tick) begin
				unique case (phase_q) inside
					PH_SETTLE: elapsed_d = done ? '0 : elapsed_inc;
					PH_FLUSH: begin
						elapsed_d = done ? '0 : elapsed_inc;
						push      = done;
						cmd.data  = CH_I;
					end
					PH_GAP: begin
						elapsed_d = done ? '0 : elapsed_inc;
						push      = done;
						cmd.data  = CH_R;
					end
					PH_WAIT_O, PH_WAIT_K: begin
						elapsed_d = done ? '0 : elapsed_inc;
						push      = done;
						cmd.kind  = KIND_REPLY_TIMEOUT;
					end
					PH_READY: begin
						if (held_q != '0) begin
							elapsed_d = done ? '0 : elapsed_inc;
							push      = done;
							cmd.kind  = KIND_CODE_TIMEOUT;
							if (done) begin
								held_d = '0;
							end
						end
					end
					default: ;
				endcase
			end else if (is_byte) begin
				unique case (phase_q) inside
					PH_FLUSH, PH_WAIT_O: elapsed_d = '0;
					PH_WAIT_K: begin
						elapsed_d = '0;
						push      = 1'b1;
						if (item.rx_byte == CH_K) begin
							cmd.kind = KIND_READY;
							held_d   = '0;
						end else begin
							cmd.kind = KIND_BAD_REPLY;
						end
					end
					PH_READY: begin
						elapsed_d = '0;
						push      = 1'b1;
						cmd.kind  = KIND_CODE;
						cmd.data  = item.rx_byte;
						cmd.pos   = held_q;
						if (held_q == LAST_POS) begin
							cmd.op = OP_CODE;
							held_d = '0;
						end else begin
							cmd.op = OP_STORE;
							held_d = held_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			elapsed_q <= '0;
			held_q    <= '0;
		end else begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			held_q    <= held_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_held_only_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != '0 |-> phase_q == PH_READY)
		else $error("Partial code held outside the ready phase.");
	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= LAST_POS)
		else $error("Byte count of the partial code out of range.");
`endif

endmodule

/* hw/rtl/irl_cmd_fifo.sv */
// Two-entry command queue between the front and back parts.
// Depends on irl_pkg for the command type.
`timescale 1ns / 1ps

module irl_cmd_fifo import irl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic space,
	input  logic pop,
	output logic avail,
	output cmd_t head
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign space = count_q != 2'd2;
	assign avail = count_q != 2'd0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push)
		else $error("Command queue pushed when full.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd0 |-> !pop)
		else $error("Command queue popped when empty.");
`endif

endmodule

/* hw/rtl/irl_back.sv */
// Back part: carries out queued commands, holds the code store and drives results.
// Depends on irl_pkg and irl_if.
`timescale 1ns / 1ps

module irl_back import irl_pkg::*; #(
	parameter int CODE_BYTES = 6
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     avail,
	input  cmd_t     head,
	output logic     pop,
	irl_out_if.source result
);

	localparam int SIDX_W = (CODE_BYTES > 1) ? $clog2(CODE_BYTES) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_BYTES - 1);

	logic [7:0]        store_q [CODE_BYTES];
	logic              run_q, out_valid_q, out_free, load_single, load_run, run_last;
	logic [POS_W-1:0]  cnt_q;
	logic [KIND_W-1:0] kind_q;
	logic [7:0]        data_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;

	assign out_free    = !out_valid_q || result.ready;
	assign pop         = avail && !run_q && out_free;
	assign load_single = pop && head.op == OP_SINGLE;
	assign load_run    = run_q && out_free;
	assign run_last    = cnt_q == LAST_POS;

	assign result.valid    = out_valid_q;
	assign result.kind     = kind_q;
	assign result.data     = data_q;
	assign result.position = pos_q;
	assign result.last     = last_q;

	always_ff @(posedge clk) begin
		if (pop && head.op != OP_SINGLE) begin
			store_q[head.pos[SIDX_W-1:0]] <= head.data;
		end
		if (load_single) begin
			kind_q <= head.kind;
			data_q <= head.data;
			pos_q  <= '0;
			last_q <= 1'b1;
		end else if (load_run) begin
			kind_q <= KIND_CODE;
			data_q <= store_q[cnt_q[SIDX_W-1:0]];
			pos_q  <= cnt_q;
			last_q <= run_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_q       <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load_single || load_run) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && head.op == OP_CODE) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (load_run) begin
				run_q <= !run_last;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> cnt_q <= LAST_POS)
		else $error("Code run counter out of range.");
	a_run_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> out_valid_q && last_q && kind_q == KIND_CODE)
		else $error("Code run ended without its final byte.");
`endif

endmodule

/* hw/rtl/ir_receiver_link_handshake_unit.sv */
// A single result passes the command queue entry and the output register. A code run,
// started by its final byte, passes the queue entry, the run state and the output
// register and gives one byte per cycle while results are taken. Throughput: one item
// per cycle while the two-entry command queue has room; the back part takes no new
// command while it plays out a completed code. Reset: arst_n clears phase, timers, queue
// and output at once and loads the register defaults; the code store is not cleared.
`timescale 1ns / 1ps

module ir_receiver_link_handshake_unit import irl_pkg::*; #(
	parameter int CODE_BYTES = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [TICK_W-1:0] wr_data,
	irl_in_if.sink            item,
	irl_out_if.source         result
);

	logic push, space, pop, avail;
	cmd_t push_cmd, head;

	irl_front #(.CODE_BYTES(CODE_BYTES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item),
		.space    (space),
		.push     (push),
		.cmd      (push_cmd)
	);

	irl_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.space    (space),
		.pop      (pop),
		.avail    (avail),
		.head     (head)
	);

	irl_back #(.CODE_BYTES(CODE_BYTES)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (avail),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the infrared receiver link handshake unit.
// Depends on irl_pkg, the stream interfaces in irl_if and ir_receiver_link_handshake_unit.
`timescale 1ns / 1ps

module testbench;
	import irl_pkg::*;

	localparam int CODE_BYTES = 6;
	localparam int BUF_IDX_W = $clog2(CODE_BYTES);
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        data;
		logic [POS_W-1:0]  pos;
		logic              last;
	} link_result_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [7:0]        rx;
		logic              typed;
		logic [KIND_W-1:0] kind;
		logic [7:0]        data;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_index;
	logic [TICK_W-1:0] wr_data;

	irl_in_if  link_in ();
	irl_out_if link_out ();

	ir_receiver_link_handshake_unit #(.CODE_BYTES(CODE_BYTES)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (link_in),
		.result   (link_out)
	);

	// Link state as this bench predicts it.
	logic [TICK_W-1:0] cfg_settle = SETTLE_RST;
	logic [TICK_W-1:0] cfg_quiet = QUIET_RST;
	logic [TICK_W-1:0] cfg_gap = SEND_GAP_RST;
	logic [TICK_W-1:0] cfg_reply = REPLY_TO_RST;
	logic [TICK_W-1:0] cfg_inter = INTER_BYTE_RST;
	phase_t            ph = PH_IDLE;
	logic [TICK_W-1:0] waited = '0;
	logic [7:0]        code_buf [CODE_BYTES];
	logic [3:0]        held = '0;
	bit                was_noop;

	link_result_t pending [$];
	link_result_t want;
	int           fails = 0;
	int           tx_idle_pct = 37;
	int           rx_idle_pct = 49;
	int           hold_asked = 0;
	int           hold_seen = 0;
	int           stall_left = 0;

	plan_row_t directed_plan [27] = '{
		'{MODE_UNUSED, 8'hFF, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'h00, 1'b0, KIND_SEND, 8'h00},
		'{MODE_TICK, 8'h00, 1'b0, KIND_SEND, 8'h00},
		'{MODE_START, 8'h00, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'hFF, 1'b0, KIND_SEND, 8'h00},
		'{MODE_TICK, 8'hFF, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'hA5, 1'b0, KIND_SEND, 8'h00},
		'{MODE_TICK, 8'h00, 1'b1, KIND_SEND, CH_I},
		'{MODE_BYTE, 8'h12, 1'b0, KIND_SEND, 8'h00},
		'{MODE_TICK, 8'h00, 1'b1, KIND_SEND, CH_R},
		'{MODE_TICK, 8'h00, 1'b1, KIND_REPLY_TIMEOUT, 8'h00},
		'{MODE_START, 8'hFF, 1'b0, KIND_SEND, 8'h00},
		'{MODE_TICK, 8'h00, 1'b0, KIND_SEND, 8'h00},
		'{MODE_TICK, 8'h00, 1'b0, KIND_SEND, 8'h00},
		'{MODE_TICK, 8'h00, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, CH_K, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, CH_O, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, CH_K, 1'b1, KIND_READY, 8'h00},
		'{MODE_TICK, 8'h00, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'h00, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'hFF, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'h55, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'hAA, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'h01, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'h80, 1'b0, KIND_SEND, 8'h00},
		'{MODE_BYTE, 8'h33, 1'b0, KIND_SEND, 8'h00},
		'{MODE_TICK, 8'h00, 1'b1, KIND_CODE_TIMEOUT, 8'h00}
	};

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic bit tick_reaches(input logic [TICK_W-1:0] lim);
		if (waited < TICK_MAX)
			waited = waited + 1'b1;
		return waited >= lim;
	endfunction

	task automatic emit(input logic [KIND_W-1:0] k, input logic [7:0] d,
		input logic [POS_W-1:0] p, input logic l);
		link_result_t r;
		r.kind = k;
		r.data = d;
		r.pos = p;
		r.last = l;
		pending.push_back(r);
	endtask

	task automatic link_step(input logic [1:0] m, input logic [7:0] b);
		int i;
		was_noop = 1'b0;
		case (m)
			MODE_START: begin
				ph = PH_SETTLE;
				waited = '0;
				held = '0;
			end
			MODE_TICK: begin
				case (ph)
					PH_SETTLE: begin
						if (tick_reaches(cfg_settle)) begin
							ph = PH_FLUSH;
							waited = '0;
						end
					end
					PH_FLUSH: begin
						if (tick_reaches(cfg_quiet)) begin
							ph = PH_GAP;
							waited = '0;
							emit(KIND_SEND, CH_I, '0, 1'b1);
						end
					end
					PH_GAP: begin
						if (tick_reaches(cfg_gap)) begin
							ph = PH_WAIT_O;
							waited = '0;
							emit(KIND_SEND, CH_R, '0, 1'b1);
						end
					end
					PH_WAIT_O, PH_WAIT_K: begin
						if (tick_reaches(cfg_reply)) begin
							ph = PH_IDLE;
							waited = '0;
							emit(KIND_REPLY_TIMEOUT, 8'h00, '0, 1'b1);
						end
					end
					PH_READY: begin
						if (held == 0) begin
							was_noop = 1'b1;
						end else if (tick_reaches(cfg_inter)) begin
							held = '0;
							waited = '0;
							emit(KIND_CODE_TIMEOUT, 8'h00, '0, 1'b1);
						end
					end
					default: begin
						was_noop = 1'b1;
					end
				endcase
			end
			MODE_BYTE: begin
				case (ph)
					PH_FLUSH: begin
						waited = '0;
					end
					PH_WAIT_O: begin
						waited = '0;
						if (b == CH_O)
							ph = PH_WAIT_K;
					end
					PH_WAIT_K: begin
						waited = '0;
						if (b == CH_K) begin
							ph = PH_READY;
							held = '0;
							emit(KIND_READY, 8'h00, '0, 1'b1);
						end else begin
							ph = PH_IDLE;
							emit(KIND_BAD_REPLY, 8'h00, '0, 1'b1);
						end
					end
					PH_READY: begin
						waited = '0;
						if (held < CODE_BYTES)
							code_buf[held[BUF_IDX_W-1:0]] = b;
						held = held + 1'b1;
						if (held >= CODE_BYTES) begin
							for (i = 0; i < CODE_BYTES; i++)
								emit(KIND_CODE, code_buf[i[BUF_IDX_W-1:0]], i[POS_W-1:0],
									i == CODE_BYTES - 1);
							held = '0;
						end
					end
					default: begin
						was_noop = 1'b1;
					end
				endcase
			end
			default: begin
				was_noop = 1'b1;
			end
		endcase
	endtask

	task automatic send_item(input logic [1:0] m, input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			link_in.valid <= 1'b0;
			@(posedge clk);
		end
		link_in.valid <= 1'b1;
		link_in.mode <= m;
		link_in.rx_byte <= b;
		do
			@(posedge clk);
		while (!link_in.ready);
	endtask

	task automatic feed(input logic [1:0] m, input logic [7:0] b);
		send_item(m, b);
		link_step(m, b);
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [TICK_W-1:0] v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
		case (idx)
			REG_SETTLE: cfg_settle = v;
			REG_QUIET: cfg_quiet = v;
			REG_SEND_GAP: cfg_gap = v;
			REG_REPLY_TO: cfg_reply = v;
			REG_INTER_BYTE: cfg_inter = v;
			default: ;
		endcase
	endtask

	task automatic write_regs(input logic [TICK_W-1:0] s, input logic [TICK_W-1:0] q,
		input logic [TICK_W-1:0] g, input logic [TICK_W-1:0] r,
		input logic [TICK_W-1:0] ib);
		put_reg(REG_SETTLE, s);
		put_reg(REG_QUIET, q);
		put_reg(REG_SEND_GAP, g);
		put_reg(REG_REPLY_TO, r);
		put_reg(REG_INTER_BYTE, ib);
		put_reg(REG_NONE, TICK_W'($urandom));
		wr_en <= 1'b0;
	endtask

	task automatic wait_quiet();
		link_in.valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	task automatic pick_item(input bit may_start, output logic [1:0] m, output logic [7:0] b);
		int r;
		r = $urandom_range(99);
		b = 8'($urandom_range(255));
		m = MODE_TICK;
		case (ph)
			PH_IDLE: begin
				if (r < 70 && may_start)
					m = MODE_START;
				else if (r < 80)
					m = MODE_TICK;
				else if (r < 90)
					m = MODE_BYTE;
				else
					m = MODE_UNUSED;
			end
			PH_SETTLE, PH_FLUSH, PH_GAP: begin
				if (r < 75)
					m = MODE_TICK;
				else if (r < 93)
					m = MODE_BYTE;
				else if (r < 97)
					m = MODE_UNUSED;
				else if (may_start)
					m = MODE_START;
			end
			PH_WAIT_O: begin
				if (r < 40) begin
					m = MODE_BYTE;
					b = CH_O;
				end else if (r < 70) begin
					m = MODE_BYTE;
				end else if (r < 95) begin
					m = MODE_TICK;
				end else begin
					m = may_start ? MODE_START : MODE_UNUSED;
				end
			end
			PH_WAIT_K: begin
				if (r < 75) begin
					m = MODE_BYTE;
					b = CH_K;
				end else if (r < 88) begin
					m = MODE_BYTE;
				end
			end
			PH_READY: begin
				if (r < 65)
					m = MODE_BYTE;
				else if (r < 95)
					m = MODE_TICK;
				else if (r < 98)
					m = MODE_UNUSED;
				else
					m = may_start ? MODE_START : MODE_BYTE;
			end
			default: ;
		endcase
	endtask

	task automatic random_items(input int n, input bit may_start);
		logic [1:0] m;
		logic [7:0] b;
		int         done;
		done = 0;
		while (done < n) begin
			pick_item(may_start, m, b);
			feed(m, b);
			if (!was_noop)
				done++;
		end
	endtask

	task automatic check_field(input string name, input int exp, input int got);
		if (exp != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp, got);
			fails++;
		end
	endtask

	initial begin
		link_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_seen) begin
				hold_seen = hold_asked;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				link_out.ready <= 1'b0;
			end else begin
				link_out.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (link_out.valid && link_out.ready) begin
			if (pending.size() == 0) begin
				$error("unexpected result: kind %0h data %0h position %0h last %0h",
					link_out.kind, link_out.data, link_out.position, link_out.last);
				fails++;
			end else begin
				want = pending.pop_front();
				check_field("kind", int'(want.kind), int'(link_out.kind));
				check_field("data", int'(want.data), int'(link_out.data));
				check_field("position", int'(want.pos), int'(link_out.position));
				check_field("last", int'(want.last), int'(link_out.last));
			end
		end
	end

	initial begin
		#8_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		logic [1:0] m;
		logic [7:0] b;
		int         depth;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		link_in.valid <= 1'b0;
		link_in.mode <= MODE_TICK;
		link_in.rx_byte <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		feed(MODE_START, 8'h00);
		repeat (5) feed(MODE_TICK, 8'($urandom_range(255)));
		feed(MODE_START, 8'h00);
		feed(MODE_BYTE, 8'h00);
		feed(MODE_BYTE, CH_O);
		feed(MODE_BYTE, 8'h58);
		wait_quiet();

		write_regs('0, 21'd1, '0, 21'd1, 21'd1);
		foreach (directed_plan[i]) begin
			send_item(directed_plan[i].mode, directed_plan[i].rx);
			depth = pending.size();
			link_step(directed_plan[i].mode, directed_plan[i].rx);
			if (directed_plan[i].typed) begin
				while (pending.size() > depth)
					void'(pending.pop_back());
				emit(directed_plan[i].kind, directed_plan[i].data, '0, 1'b1);
			end
		end
		wait_quiet();

		write_regs(TICK_W'($urandom_range(3)), TICK_W'($urandom_range(4, 1)),
			TICK_W'($urandom_range(3)), TICK_W'($urandom_range(6, 1)), TICK_MAX);
		random_items(35, 1'b1);
		wait_quiet();

		tx_idle_pct = 49;
		rx_idle_pct = 37;
		write_regs(TICK_W'($urandom_range(3)), TICK_W'($urandom_range(4, 1)),
			TICK_W'($urandom_range(3)), TICK_MAX, TICK_W'($urandom_range(3, 1)));
		random_items(35, 1'b1);
		wait_quiet();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (ph != PH_READY) begin
			pick_item(1'b1, m, b);
			feed(m, b);
		end
		wait_quiet();
		write_regs(TICK_MAX, TICK_MAX, TICK_MAX, TICK_W'($urandom_range(8, 1)),
			TICK_W'($urandom_range(3, 1)));
		hold_asked++;
		random_items(35, 1'b0);
		wait_quiet();

		if (fails == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

/* ir_receiver_link_handshake_unit.f */
hw/rtl/irl_pkg.sv
hw/rtl/irl_if.sv
hw/rtl/irl_front.sv
hw/rtl/irl_cmd_fifo.sv
hw/rtl/irl_back.sv
hw/rtl/ir_receiver_link_handshake_unit.sv
bench/testbench.sv
